// ===== src/cunrank_pkg.sv =====
// Shared constants for the combination unrank unit.
// No dependencies; used by the top level and its checker.
`default_nettype none

package cunrank_pkg;

    localparam int unsigned MAX_BITS_DEF = 32;

    localparam int unsigned RANK_W     = 30;
    localparam int unsigned OCC_W      = 32;
    localparam int unsigned CNT_W      = 6;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 6;

    // Binomials are held saturated at 2**30, which is above every rank.
    localparam int unsigned VAL_W = RANK_W + 1;
    localparam int unsigned SUM_W = VAL_W + 1;

    localparam logic [CFG_IDX_W-1:0] REG_BIT_COUNT  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ONES_COUNT = 1'd1;

    localparam logic [CNT_W-1:0] BIT_COUNT_RST  = 6'd32;
    localparam logic [CNT_W-1:0] ONES_COUNT_RST = 6'd16;

endpackage

`default_nettype wire

// ===== src/combination_unrank_unit.sv =====
// Combination unrank unit: turns a rank into the n-bit string with k ones.
// Depends on cunrank_pkg; holds its own binomial table memory.
// From start it reads the total, compares it, then reads and compares once per decided
// position before o_strobe; a new word can be taken in the o_strobe cycle itself.
// The rate is set by one table read and one pass through the shared adder
// per position. After reset the table is built with busy high, and the
// receiver cannot stall results.
`default_nettype none

module combination_unrank_unit #(
    parameter int unsigned MAX_BITS = cunrank_pkg::MAX_BITS_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 start,
    output logic                                      busy,
    input  wire logic [cunrank_pkg::RANK_W-1:0]       i_rank,
    input  wire logic                                 i_cfg_we,
    input  wire logic [cunrank_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [cunrank_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output logic      [cunrank_pkg::OCC_W-1:0]        o_occupancy,
    output logic                                      o_out_of_range,
    output logic                                      o_strobe
);

    localparam int unsigned TW    = MAX_BITS + 1;
    localparam int unsigned DEPTH = TW * TW;
    localparam int unsigned AW    = $clog2(TW);
    localparam int unsigned MW    = $clog2(DEPTH);
    localparam int unsigned VW    = cunrank_pkg::VAL_W;
    localparam int unsigned SW    = cunrank_pkg::SUM_W;
    localparam int unsigned CW    = cunrank_pkg::CNT_W;
    localparam int unsigned RW    = cunrank_pkg::RANK_W;
    localparam int unsigned OW    = cunrank_pkg::OCC_W;
    localparam logic [VW-1:0] BIN_SAT = {1'b1, {(VW-1){1'b0}}};

    typedef enum logic [6:0] {
        S_FILL_RD  = 7'b0000001,
        S_FILL_WR  = 7'b0000010,
        S_IDLE     = 7'b0000100,
        S_TOT_RD   = 7'b0001000,
        S_TOT_CMP  = 7'b0010000,
        S_STEP_RD  = 7'b0100000,
        S_STEP_CMP = 7'b1000000
    } t_state;

    function automatic logic [MW-1:0] tab_addr(input logic [AW-1:0] row,
                                               input logic [AW-1:0] col);
        return MW'(MW'(row) * MW'(TW) + MW'(col));
    endfunction

    t_state            r_state;
    logic [CW-1:0]     r_bit_count;
    logic [CW-1:0]     r_ones_count;
    logic [AW-1:0]     r_fa;
    logic [AW-1:0]     r_fb;
    logic [VW-1:0]     r_prev;
    logic [VW-1:0]     r_rdata;
    logic [RW-1:0]     r_rank;
    logic [AW-1:0]     r_rem;
    logic [AW-1:0]     r_pos;
    logic [CW-1:0]     r_ones;
    logic [OW-1:0]     r_occ;
    logic              r_oor;
    logic              r_strobe;
    logic [VW-1:0]     r_mem [DEPTH];

    logic [AW-1:0]     cfg_n;
    logic              fits;
    logic              fill;
    logic [MW-1:0]     rd_addr;
    logic [MW-1:0]     wr_addr;
    logic [VW-1:0]     c_val;
    logic [SW-1:0]     op_a;
    logic [SW-1:0]     op_b;
    logic [SW-1:0]     sum;
    logic              is_less;
    logic [VW-1:0]     sat_sum;
    logic [VW-1:0]     fill_val;

    assign cfg_n = (r_bit_count > CW'(MAX_BITS)) ? AW'(MAX_BITS) : r_bit_count[AW-1:0];
    assign fits  = (r_ones <= CW'(r_rem));
    assign fill  = (r_state == S_FILL_WR);

    always_comb begin
        rd_addr = '0;
        unique case (r_state)
            S_FILL_RD: begin
                rd_addr = tab_addr(AW'(r_fa - AW'(1)), r_fb);
            end
            S_TOT_RD: begin
                if (fits) begin
                    rd_addr = tab_addr(r_rem, r_ones[AW-1:0]);
                end
            end
            S_STEP_RD: begin
                if (fits) begin
                    rd_addr = tab_addr(AW'(r_rem - AW'(1)), AW'(r_ones[AW-1:0] - AW'(1)));
                end
            end
            default: begin
                rd_addr = '0;
            end
        endcase
    end

    assign wr_addr = tab_addr(r_fa, r_fb);
    assign c_val   = fits ? r_rdata : '0;

    // One adder serves the table build (add) and the rank compare (subtract).
    assign op_a    = fill ? SW'(r_prev) : SW'(r_rank);
    assign op_b    = fill ? SW'(r_rdata) : ~SW'(c_val);
    assign sum     = op_a + op_b + SW'(!fill);
    assign is_less = sum[SW-1];
    assign sat_sum = (sum[SW-1] | sum[SW-2]) ? BIN_SAT : sum[VW-1:0];

    assign fill_val = (r_fb == '0) ? VW'(1) : ((r_fa == '0) ? '0 : sat_sum);

    always_ff @(posedge i_clk) begin
        if (fill) begin
            r_mem[wr_addr] <= fill_val;
        end
        r_rdata <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_FILL_RD;
            r_fa         <= '0;
            r_fb         <= '0;
            r_bit_count  <= cunrank_pkg::BIT_COUNT_RST;
            r_ones_count <= cunrank_pkg::ONES_COUNT_RST;
            r_strobe     <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    cunrank_pkg::REG_BIT_COUNT:  r_bit_count  <= i_cfg_data;
                    cunrank_pkg::REG_ONES_COUNT: r_ones_count <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            unique case (r_state)
                S_FILL_RD: begin
                    r_state <= S_FILL_WR;
                end
                S_FILL_WR: begin
                    r_prev <= r_rdata;
                    if (r_fb == AW'(MAX_BITS)) begin
                        r_fb <= '0;
                        if (r_fa == AW'(MAX_BITS)) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_fa    <= AW'(r_fa + AW'(1));
                            r_state <= S_FILL_RD;
                        end
                    end else begin
                        r_fb    <= AW'(r_fb + AW'(1));
                        r_state <= S_FILL_RD;
                    end
                end
                S_IDLE: begin
                    if (start) begin
                        r_rank  <= i_rank;
                        r_rem   <= cfg_n;
                        r_pos   <= '0;
                        r_ones  <= r_ones_count;
                        r_occ   <= '0;
                        r_state <= S_TOT_RD;
                    end
                end
                S_TOT_RD: begin
                    r_state <= S_TOT_CMP;
                end
                S_TOT_CMP: begin
                    r_oor <= !is_less;
                    if ((r_rem == '0) || (r_ones == '0)) begin
                        r_strobe <= 1'b1;
                        r_state  <= S_IDLE;
                    end else begin
                        r_state <= S_STEP_RD;
                    end
                end
                S_STEP_RD: begin
                    r_state <= S_STEP_CMP;
                end
                S_STEP_CMP: begin
                    if (is_less) begin
                        r_occ  <= r_occ | (OW'(1) << r_pos);
                        r_ones <= CW'(r_ones - CW'(1));
                    end else begin
                        r_rank <= sum[RW-1:0];
                    end
                    r_rem <= AW'(r_rem - AW'(1));
                    r_pos <= AW'(r_pos + AW'(1));
                    if ((r_rem == AW'(1)) || (is_less && (r_ones == CW'(1)))) begin
                        r_strobe <= 1'b1;
                        r_state  <= S_IDLE;
                    end else begin
                        r_state <= S_STEP_RD;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy           = !i_rst_n || (r_state != S_IDLE);
    assign o_occupancy    = r_occ;
    assign o_out_of_range = r_oor;
    assign o_strobe       = r_strobe;

endmodule

`default_nettype wire

// ===== src/cunrank_chk.sv =====
// Port-level checker for the combination unrank unit, with its bind.
// Depends on cunrank_pkg and on the top level's port list.
`default_nettype none

module cunrank_chk (
    input wire logic                               i_clk,
    input wire logic                               i_rst_n,
    input wire logic                               start,
    input wire logic                               busy,
    input wire logic [cunrank_pkg::OCC_W-1:0]      o_occupancy,
    input wire logic                               o_out_of_range,
    input wire logic                               o_strobe
);

    a_accept_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("An accepted word did not make the unit busy.");

    a_strobe_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("A result word appeared while the unit was still busy.");

    a_strobe_after_work : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("A result word appeared without work before it.");

    a_strobe_single : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("A result word was repeated.");

    a_result_known : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !$isunknown({o_occupancy, o_out_of_range}))
        else $error("A result word carried unknown bits.");

endmodule

bind combination_unrank_unit cunrank_chk u_cunrank_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_occupancy    (o_occupancy),
    .o_out_of_range (o_out_of_range),
    .o_strobe       (o_strobe)
);

`default_nettype wire

// ===== sim/tb_combination_unrank_unit.sv =====
// Self-checking testbench for combination_unrank_unit: ranks go in, and each
// occupancy word and out-of-range flag is checked against a built-in predictor.
// Depends on cunrank_pkg and the unit itself; reads no files.
`timescale 1ns / 1ps

module tb_combination_unrank_unit;

    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int unsigned SETTLE_CYCLES = 2 * cunrank_pkg::MAX_BITS_DEF + 16;
    localparam int unsigned PHASES = 14;
    localparam int unsigned WORDS_PER_PHASE = 100;
    localparam int unsigned RW = cunrank_pkg::RANK_W;
    localparam int unsigned IW = cunrank_pkg::CFG_IDX_W;
    localparam int unsigned DW = cunrank_pkg::CFG_DATA_W;
    localparam int unsigned OW = cunrank_pkg::OCC_W;
    localparam int unsigned MAXB = cunrank_pkg::MAX_BITS_DEF;

    typedef enum logic [1:0] {JOB_RANK, JOB_CFG, JOB_DRAIN} t_job_kind;

    typedef struct {
        t_job_kind kind;
        logic [RW-1:0] rank;
        logic [IW-1:0] idx;
        logic [DW-1:0] data;
        int unsigned gap_pct;
    } t_job;

    typedef struct packed {
        logic [OW-1:0] occ;
        logic oor;
    } t_combo;

    logic i_clk;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [RW-1:0] i_rank = '0;
    logic i_cfg_we = 1'b0;
    logic [IW-1:0] i_cfg_idx = '0;
    logic [DW-1:0] i_cfg_data = '0;
    logic [OW-1:0] o_occupancy;
    logic o_out_of_range;
    logic o_strobe;

    t_job rank_jobs[$];
    t_combo pending_strings[$];

    logic [DW-1:0] model_bits;
    logic [DW-1:0] model_ones;

    int unsigned ranks_taken = 0;
    int unsigned strings_seen = 0;
    int unsigned flagged_seen = 0;
    int unsigned settings_made = 0;
    int unsigned fail_cnt = 0;
    int unsigned cycle_cnt = 0;

    logic drv_start;
    logic [RW-1:0] drv_rank;
    logic drv_we;
    logic [IW-1:0] drv_idx;
    logic [DW-1:0] drv_data;

    combination_unrank_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_rank        (i_rank),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .o_occupancy   (o_occupancy),
        .o_out_of_range(o_out_of_range),
        .o_strobe      (o_strobe)
    );

    function automatic longint unsigned binom(longint unsigned a, longint unsigned b);
        longint unsigned r;
        longint unsigned i;
        r = 1;
        if (b > a) return 0;
        if (b > a - b) b = a - b;
        for (i = 0; i < b; i++) r = r * (a - i) / (i + 1);
        return r;
    endfunction

    function automatic longint unsigned combo_total(logic [DW-1:0] nbits,
                                                    logic [DW-1:0] nones);
        longint unsigned n;
        n = nbits;
        if (n > MAXB) n = MAXB;
        return binom(n, nones);
    endfunction

    function automatic t_combo unrank_string(logic [RW-1:0] rank_in,
                                             logic [DW-1:0] nbits,
                                             logic [DW-1:0] nones);
        longint unsigned rest;
        longint unsigned n;
        longint unsigned k;
        longint unsigned c;
        longint unsigned pos;
        t_combo res;
        rest = rank_in;
        n = nbits;
        k = nones;
        if (n > MAXB) n = MAXB;
        res.occ = '0;
        res.oor = (rest >= binom(n, k));
        for (pos = 0; pos < n && k != 0; pos++) begin
            c = binom(n - pos - 1, k - 1);
            if (rest < c) begin
                res.occ[pos] = 1'b1;
                k--;
            end else begin
                rest -= c;
            end
        end
        return res;
    endfunction

    task automatic add_rank(logic [RW-1:0] r, int unsigned pct);
        t_job j;
        j.kind = JOB_RANK;
        j.rank = r;
        j.idx = '0;
        j.data = '0;
        j.gap_pct = pct;
        rank_jobs.insert(rank_jobs.size(), j);
    endtask

    task automatic add_job(t_job_kind kind, logic [IW-1:0] idx, logic [DW-1:0] data);
        t_job j;
        j.kind = kind;
        j.rank = '0;
        j.idx = idx;
        j.data = data;
        j.gap_pct = 0;
        rank_jobs.insert(rank_jobs.size(), j);
    endtask

    task automatic add_settings(logic [DW-1:0] nbits, logic [DW-1:0] nones);
        if ($urandom_range(1)) begin
            add_job(JOB_CFG, cunrank_pkg::REG_BIT_COUNT, nbits);
            add_job(JOB_CFG, cunrank_pkg::REG_ONES_COUNT, nones);
        end else begin
            add_job(JOB_CFG, cunrank_pkg::REG_ONES_COUNT, nones);
            add_job(JOB_CFG, cunrank_pkg::REG_BIT_COUNT, nbits);
        end
        settings_made++;
    endtask

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles.", cycle_cnt);
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        drv_start = start;
        drv_rank = i_rank;
        drv_we = 1'b0;
        drv_idx = i_cfg_idx;
        drv_data = i_cfg_data;
        if (i_rst_n) begin
            if (start && !busy) drv_start = 1'b0;
            if (!drv_start && rank_jobs.size() > 0) begin
                case (rank_jobs[0].kind)
                    JOB_RANK: begin
                        if ($urandom_range(99) >= rank_jobs[0].gap_pct) begin
                            drv_start = 1'b1;
                            drv_rank = rank_jobs[0].rank;
                            void'(rank_jobs.pop_front());
                        end
                    end
                    JOB_CFG: begin
                        if (!start && !busy && ranks_taken == strings_seen) begin
                            drv_we = 1'b1;
                            drv_idx = rank_jobs[0].idx;
                            drv_data = rank_jobs[0].data;
                            void'(rank_jobs.pop_front());
                        end
                    end
                    default: begin
                        if (!start && !busy && ranks_taken == strings_seen) begin
                            void'(rank_jobs.pop_front());
                        end
                    end
                endcase
            end
        end
        start <= drv_start;
        i_rank <= drv_rank;
        i_cfg_we <= drv_we;
        i_cfg_idx <= drv_idx;
        i_cfg_data <= drv_data;
    end

    always @(posedge i_clk) begin
        t_combo want;
        if (!i_rst_n) begin
            model_bits = cunrank_pkg::BIT_COUNT_RST;
            model_ones = cunrank_pkg::ONES_COUNT_RST;
        end else begin
            if (o_strobe) begin
                strings_seen <= strings_seen + 1;
                if (pending_strings.size() == 0) begin
                    $error("Result word with no rank waiting: occupancy %h", o_occupancy);
                    fail_cnt++;
                end else begin
                    want = pending_strings.pop_front();
                    if (o_occupancy !== want.occ) begin
                        $error("occupancy: expected %h, actual %h", want.occ, o_occupancy);
                        fail_cnt++;
                    end
                    if (o_out_of_range !== want.oor) begin
                        $error("out_of_range: expected %0b, actual %0b",
                               want.oor, o_out_of_range);
                        fail_cnt++;
                    end
                    if (want.oor) flagged_seen++;
                end
            end
            if (start && !busy) begin
                pending_strings.insert(pending_strings.size(),
                                       unrank_string(i_rank, model_bits, model_ones));
                ranks_taken <= ranks_taken + 1;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    cunrank_pkg::REG_BIT_COUNT: model_bits = i_cfg_data;
                    cunrank_pkg::REG_ONES_COUNT: model_ones = i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    initial begin
        logic [DW-1:0] nbits;
        logic [DW-1:0] nones;
        logic [DW-1:0] cap;
        longint unsigned total;
        int unsigned pct;
        int unsigned sel;
        logic [RW-1:0] r;
        int unsigned gap_table[4];

        gap_table = '{0, 71, 0, 33};

        // Reset settings first: n = 32, k = 16.
        add_rank('0, 0);
        add_rank(RW'(combo_total(cunrank_pkg::BIT_COUNT_RST,
                                 cunrank_pkg::ONES_COUNT_RST) - 1), 0);
        add_rank(RW'(combo_total(cunrank_pkg::BIT_COUNT_RST,
                                 cunrank_pkg::ONES_COUNT_RST)), 0);
        add_rank('1, 0);
        add_settings(6'd5, 6'd2);
        add_rank(30'd0, 0);
        add_rank(30'd9, 0);
        add_rank(30'd10, 0);
        add_settings(6'd0, 6'd0);
        add_rank(30'd0, 0);
        add_rank(30'd1, 0);
        // Bit count above the maximum saturates.
        add_settings(6'd63, 6'd32);
        add_rank(30'd0, 0);
        add_rank(30'd1, 0);
        // More ones than positions.
        add_settings(6'd3, 6'd5);
        add_rank(30'd0, 0);
        add_settings(6'd32, 6'd1);
        add_rank(30'd31, 0);
        add_rank(30'd0, 0);
        add_rank(30'd32, 0);
        add_settings(6'd32, 6'd0);
        add_rank(30'd0, 0);
        add_rank(30'd5, 0);
        add_settings(6'd1, 6'd1);
        add_rank(30'd0, 0);

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin nbits = 6'd32; nones = 6'd16; end
                1: begin nbits = 6'd63; nones = 6'd63; end
                2: begin nbits = 6'd0; nones = 6'd0; end
                3: begin nbits = 6'd32; nones = 6'd32; end
                4: begin nbits = 6'd33; nones = 6'd15; end
                5: begin nbits = 6'd7; nones = 6'd3; end
                default: begin
                    nbits = 6'($urandom_range(63));
                    cap = (nbits > MAXB) ? 6'(MAXB) : nbits;
                    nones = ($urandom_range(99) < 80) ? 6'($urandom_range(cap))
                                                      : 6'($urandom_range(63));
                end
            endcase
            add_settings(nbits, nones);
            total = combo_total(nbits, nones);
            pct = gap_table[p % 4];
            for (int i = 0; i < WORDS_PER_PHASE; i++) begin
                if (i == WORDS_PER_PHASE / 2 && p % 4 == 1) add_job(JOB_DRAIN, '0, '0);
                sel = $urandom_range(99);
                if (total == 0 || sel < 10) begin
                    r = RW'($urandom);
                end else if (sel < 16) begin
                    r = RW'(total - 1 + $urandom_range(1));
                end else begin
                    r = RW'($urandom_range(32'(total - 1)));
                end
                add_rank(r, pct);
            end
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(posedge i_clk);
        while (rank_jobs.size() != 0 || start || ranks_taken != strings_seen);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (pending_strings.size() != 0) begin
            $error("%0d expected words never arrived", pending_strings.size());
            fail_cnt++;
        end
        $display("Checked %0d result words over %0d register settings, %0d out of range.",
                 strings_seen, settings_made, flagged_seen);
        if (fail_cnt == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
